FILE: design/rdac_pkg.sv
// ============================================================================
// rdac_pkg
// Shared types and constants of the RGBA depth and alpha converter.
// ============================================================================
package rdac_pkg;

    localparam int CH_W       = 16;               // one channel at full depth
    localparam int BYTE_W     = 8;                // one channel of RGBA8
    localparam int PROD_W     = 2 * CH_W;         // channel times alpha
    localparam int NUM_W      = CH_W + BYTE_W;    // channel times target scale
    localparam int NUM_LANES  = 4;                // red, green, blue, alpha
    localparam int DIV_STEPS  = CH_W;             // one quotient bit per stage
    localparam int PIPE_DEPTH = DIV_STEPS + 3;    // input, prep, divider, output
    localparam int CFG_IDX_W  = 3;

    localparam logic [CH_W-1:0] CH_MAX   = '1;
    localparam logic [CH_W-1:0] BYTE_MAX = CH_W'({BYTE_W{1'b1}});

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION   = 3'd0,
        CFG_HOST_DEPTH  = 3'd1,
        CFG_HOST_ALPHA  = 3'd2,
        CFG_HOST_PREM   = 3'd3,
        CFG_GUEST_PREM  = 3'd4
    } t_cfg_index;

    // how one channel gets its result
    typedef enum logic [2:0] {
        LM_PASS  = 3'd0,    // value already known at decode
        LM_DIV   = 3'd1,    // round(num / divisor) through the divider
        LM_K255  = 3'd2,    // round(prod / 255)
        LM_K255X = 3'd3,    // round(prod * 257 / 255)
        LM_K257  = 3'd4,    // round(prod / 257)
        LM_KBIG  = 3'd5     // round(prod / (65535 * 257))
    } t_lane_mode;

    typedef struct packed {
        t_lane_mode        mode;
        logic [CH_W-1:0]   pass_val;
        logic [PROD_W-1:0] prod;
        logic [NUM_W-1:0]  num;
        logic [CH_W-1:0]   divisor;
    } t_lane_in;

endpackage

FILE: design/rgba_depth_alpha_converter_unit.sv
// ============================================================================
// rgba_depth_alpha_converter_unit
// Converts one pixel per beat between a host format and RGBA8, with
// premultiply or unpremultiply between alpha conventions.
// ============================================================================
// Usage:
//   slave stream: tdata carries red, green, blue, alpha (16 bits each, red
//   lowest), tuser carries the pixel present flag.
//   master stream: tdata carries the converted red, green, blue, alpha in the
//   same order, tuser bit 0 the colour write flag and bit 1 the alpha write
//   flag.
//   config channel: index selects direction, host depth, host alpha, host
//   premultiplied, guest premultiplied; always ready, write only when idle.
// Timing:
//   one pixel per clock while the receiver keeps taking results. The
//   depth is set by the 16-stage restoring divider for unpremultiply, one
//   quotient bit per stage, plus input, setup and output registers.
// Reset and stall:
//   reset empties the pipeline and loads the register defaults (host to
//   RGBA8, 8-bit host with straight alpha, premultiplied guest). When the
//   receiver stalls with a result waiting, the whole pipeline holds and
//   tready drops on the slave side; no beat is lost or repeated.
// ============================================================================
module rgba_depth_alpha_converter_unit
    import rdac_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,

    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic                      i_cfg_data,

    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [NUM_LANES*CH_W-1:0] i_s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic [0:0]                i_s_axis_tuser,   // pixel_present

    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [NUM_LANES*CH_W-1:0] o_m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic [1:0]                o_m_axis_tuser    // colour_write, alpha_write
);

    logic                  r_direction;
    logic                  r_host_depth;
    logic                  r_host_alpha;
    logic                  r_host_prem;
    logic                  r_guest_prem;
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [1:0]            r_flags [PIPE_DEPTH];

    logic                  w_en;
    logic                  w_present;
    logic                  w_wide;
    logic                  w_t255;
    logic [CH_W-1:0]       w_t_max;
    logic [CH_W-1:0]       w_a;
    logic                  w_pre;
    logic                  w_unp;
    logic [1:0]            w_flags;
    logic [CH_W-1:0]       w_c     [NUM_LANES-1];
    t_lane_in              w_lane  [NUM_LANES];
    logic [CH_W-1:0]       w_value [NUM_LANES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_host_depth <= 1'b0;
            r_host_alpha <= 1'b1;
            r_host_prem  <= 1'b0;
            r_guest_prem <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIRECTION:  r_direction  <= i_cfg_data;
                CFG_HOST_DEPTH: r_host_depth <= i_cfg_data;
                CFG_HOST_ALPHA: r_host_alpha <= i_cfg_data;
                CFG_HOST_PREM:  r_host_prem  <= i_cfg_data;
                CFG_GUEST_PREM: r_guest_prem <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the whole pipeline moves whenever the output slot is free or taken
    assign w_en            = !r_vld[PIPE_DEPTH-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    always_comb begin
        w_present = i_s_axis_tuser[0];
        w_wide    = !r_direction && r_host_depth;
        w_t255    = !(r_direction && r_host_depth);
        w_t_max   = w_t255 ? BYTE_MAX : CH_MAX;

        if (!r_direction && !r_host_alpha) begin
            w_a = r_host_depth ? CH_MAX : BYTE_MAX;
        end else if (w_wide) begin
            w_a = i_s_axis_tdata[3*CH_W +: CH_W];
        end else begin
            w_a = CH_W'(i_s_axis_tdata[3*CH_W +: BYTE_W]);
        end

        w_pre = r_direction ? (!r_guest_prem && r_host_prem && r_host_alpha)
                            : (r_guest_prem && !r_host_prem && r_host_alpha);
        w_unp = (r_direction ? (r_guest_prem && !r_host_prem)
                             : (!r_guest_prem && r_host_prem))
                && r_host_alpha && (w_a != '0);

        w_flags[0] = !r_direction || w_present;
        w_flags[1] = !r_direction || (w_present && r_host_alpha);

        for (int i = 0; i < NUM_LANES - 1; i++) begin
            w_c[i] = w_wide ? i_s_axis_tdata[i*CH_W +: CH_W]
                            : CH_W'(i_s_axis_tdata[i*CH_W +: BYTE_W]);
            w_lane[i].prod     = PROD_W'(w_c[i]) * PROD_W'(w_a);
            w_lane[i].num      = w_t255
                ? NUM_W'({w_c[i], 8'h00}) - NUM_W'(w_c[i])
                : NUM_W'({w_c[i][BYTE_W-1:0], 16'h0000}) - NUM_W'(w_c[i]);
            w_lane[i].divisor  = w_a;
            w_lane[i].mode     = LM_PASS;
            w_lane[i].pass_val = '0;
            priority if (!w_present) begin
                w_lane[i].pass_val = '0;
            end else if (w_unp) begin
                // colour at or above alpha saturates
                if (w_c[i] >= w_a) begin
                    w_lane[i].pass_val = w_t_max;
                end else begin
                    w_lane[i].mode = LM_DIV;
                end
            end else if (w_pre) begin
                if (!r_host_depth) begin
                    w_lane[i].mode = LM_K255;
                end else begin
                    w_lane[i].mode = r_direction ? LM_K255X : LM_KBIG;
                end
            end else if (w_wide) begin
                w_lane[i].mode = LM_K257;
                w_lane[i].prod = PROD_W'(w_c[i]);
            end else if (r_direction && r_host_depth) begin
                w_lane[i].pass_val = {w_c[i][BYTE_W-1:0], w_c[i][BYTE_W-1:0]};
            end else begin
                w_lane[i].pass_val = w_c[i];
            end
        end

        // alpha lane
        w_lane[NUM_LANES-1].prod     = PROD_W'(w_a);
        w_lane[NUM_LANES-1].num      = '0;
        w_lane[NUM_LANES-1].divisor  = w_a;
        w_lane[NUM_LANES-1].mode     = LM_PASS;
        w_lane[NUM_LANES-1].pass_val = '0;
        if (w_present) begin
            if (!r_direction) begin
                if (r_host_depth && r_host_alpha) begin
                    w_lane[NUM_LANES-1].mode = LM_K257;
                end else if (r_host_alpha) begin
                    w_lane[NUM_LANES-1].pass_val = w_a;
                end else begin
                    w_lane[NUM_LANES-1].pass_val = BYTE_MAX;
                end
            end else if (r_host_alpha) begin
                w_lane[NUM_LANES-1].pass_val = r_host_depth
                    ? {w_a[BYTE_W-1:0], w_a[BYTE_W-1:0]} : w_a;
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rdac_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_lane  (w_lane[g]),
            .o_value (w_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_flags[0] <= w_flags;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_flags[k] <= r_flags[k-1];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign o_m_axis_tdata  = {w_value[3], w_value[2], w_value[1], w_value[0]};
    assign o_m_axis_tuser  = r_flags[PIPE_DEPTH-1];

endmodule

FILE: design/rdac_lane.sv
// ============================================================================
// rdac_lane
// Arithmetic pipeline of one channel: constant-ratio rounding and a
// restoring divider, one quotient bit per stage.
// ============================================================================
module rdac_lane
    import rdac_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_en,
    input  t_lane_in        i_lane,
    output logic [CH_W-1:0] o_value
);

    localparam int Z_W  = 33;            // rounding numerator
    localparam int M_W  = Z_W + 9;       // numerator times reciprocal
    localparam int DV_W = CH_W + 1;      // twice the divisor
    localparam int X_W  = NUM_W + 2;     // divider numerator
    localparam int SHIFT_SMALL = 16;
    localparam int SHIFT_BIG   = 32;
    localparam int CONST_DONE  = 3;      // stage index where the constant path ends

    localparam logic [Z_W-1:0] RND_255  = Z_W'(127);
    localparam logic [Z_W-1:0] RND_257  = Z_W'(128);
    localparam logic [Z_W-1:0] DIV_255  = Z_W'(255);
    localparam logic [Z_W-1:0] DIV_257  = Z_W'(257);
    localparam logic [Z_W-1:0] DIV_BIG  = Z_W'(16842495);
    localparam logic [Z_W-1:0] RND_BIG  = Z_W'(8421247);

    function automatic logic f_is_k255(t_lane_mode m);
        return (m == LM_K255) || (m == LM_K255X);
    endfunction

    function automatic logic f_is_const(t_lane_mode m);
        return (m == LM_K255) || (m == LM_K255X) || (m == LM_K257) || (m == LM_KBIG);
    endfunction

    t_lane_in         r_in;
    t_lane_mode       r_mode [DIV_STEPS+1];
    logic [CH_W-1:0]  r_side [DIV_STEPS+1];
    logic [DV_W-1:0]  r_rem  [DIV_STEPS+1];
    logic [CH_W-1:0]  r_xq   [DIV_STEPS+1];
    logic [DV_W-1:0]  r_dv   [DIV_STEPS+1];
    logic [Z_W-1:0]   r_z    [CONST_DONE];
    logic [M_W-1:0]   r_m1;
    logic [CH_W-1:0]  r_q0;
    logic [Z_W-1:0]   r_qk;
    logic [CH_W-1:0]  r_out;

    logic [Z_W-1:0]   n_z0;
    logic [X_W-1:0]   n_x0;
    logic [M_W-1:0]   n_m1;
    logic [CH_W-1:0]  n_q0;
    logic [Z_W-1:0]   n_qk;
    logic [CH_W-1:0]  n_side3;
    logic [DV_W-1:0]  n_rem  [DIV_STEPS+1];
    logic [CH_W-1:0]  n_xq   [DIV_STEPS+1];
    logic [DV_W:0]    w_trial [1:DIV_STEPS];
    logic             w_ge    [1:DIV_STEPS];
    logic [Z_W-1:0]   w_rem_k;
    logic [Z_W-1:0]   w_k;

    // numerator setup for both paths
    always_comb begin
        unique case (r_in.mode)
            LM_K255:  n_z0 = Z_W'(r_in.prod) + RND_255;
            LM_K255X: n_z0 = Z_W'({r_in.prod[23:0], 8'h00}) + Z_W'(r_in.prod) + RND_255;
            LM_K257:  n_z0 = Z_W'(r_in.prod) + RND_257;
            LM_KBIG:  n_z0 = Z_W'(r_in.prod) + RND_BIG;
            default:  n_z0 = Z_W'(r_in.prod);
        endcase
        // round(num / d) = floor((2 num + d) / (2 d))
        n_x0     = X_W'({r_in.num, 1'b0}) + X_W'(r_in.divisor);
    end

    // restoring divider, quotient bits shift in behind the numerator bits
    always_comb begin
        n_rem[0] = DV_W'(n_x0[X_W-1:CH_W]);
        n_xq[0]  = n_x0[CH_W-1:0];
        for (int k = 1; k <= DIV_STEPS; k++) begin
            w_trial[k] = {r_rem[k-1], r_xq[k-1][CH_W-1]};
            w_ge[k]    = w_trial[k] >= {1'b0, r_dv[k-1]};
            n_rem[k]   = w_ge[k] ? DV_W'(w_trial[k] - {1'b0, r_dv[k-1]})
                                 : DV_W'(w_trial[k]);
            n_xq[k]    = {r_xq[k-1][CH_W-2:0], w_ge[k]};
        end
    end

    // division by a constant: reciprocal estimate, then one correction
    always_comb begin
        n_m1 = f_is_k255(r_mode[0]) ? M_W'({r_z[0], 8'h00}) + M_W'(r_z[0])
                                    : M_W'({r_z[0], 8'h00}) - M_W'(r_z[0]);

        n_q0 = (r_mode[1] == LM_KBIG) ? CH_W'(r_m1 >> SHIFT_BIG)
                                      : r_m1[SHIFT_SMALL +: CH_W];
        if (r_mode[1] == LM_KBIG) begin
            n_qk = Z_W'(n_q0[BYTE_W-1:0]) * DIV_BIG;
        end else if (f_is_k255(r_mode[1])) begin
            n_qk = Z_W'({n_q0, 8'h00}) - Z_W'(n_q0);
        end else begin
            n_qk = Z_W'({n_q0, 8'h00}) + Z_W'(n_q0);
        end

        w_rem_k = r_z[2] - r_qk;
        if (r_mode[2] == LM_KBIG) begin
            w_k = DIV_BIG;
        end else if (f_is_k255(r_mode[2])) begin
            w_k = DIV_255;
        end else begin
            w_k = DIV_257;
        end
        if (!f_is_const(r_mode[2])) begin
            n_side3 = r_side[2];
        end else if (w_rem_k >= w_k) begin
            n_side3 = r_q0 + CH_W'(1);
        end else begin
            n_side3 = r_q0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in      <= i_lane;
            r_mode[0] <= r_in.mode;
            r_side[0] <= r_in.pass_val;
            r_rem[0]  <= n_rem[0];
            r_xq[0]   <= n_xq[0];
            r_dv[0]   <= {r_in.divisor, 1'b0};
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_mode[k] <= r_mode[k-1];
                r_side[k] <= (k == CONST_DONE) ? n_side3 : r_side[k-1];
                r_rem[k]  <= n_rem[k];
                r_xq[k]   <= n_xq[k];
                r_dv[k]   <= r_dv[k-1];
            end
            r_z[0] <= n_z0;
            r_z[1] <= r_z[0];
            r_z[2] <= r_z[1];
            r_m1   <= n_m1;
            r_q0   <= n_q0;
            r_qk   <= n_qk;
            r_out  <= (r_mode[DIV_STEPS] == LM_DIV) ? r_xq[DIV_STEPS] : r_side[DIV_STEPS];
        end
    end

    assign o_value = r_out;

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGBA depth and alpha converter. A directed table
// covers extremes under eight register settings, then random pixels run under
// many settings. Each accepted pixel is converted by an in-bench predictor, or
// hand checked, and compared, field by field, against the master stream in order.
// ----------------------------------------------------------------------------
module testbench;
    import rdac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int NUM_PHASES  = 30;

    typedef struct packed {
        logic direction;
        logic host_depth;
        logic has_alpha;
        logic host_prem;
        logic guest_prem;
    } t_conv_cfg;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            present;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            colour_write;
        logic            alpha_write;
    } t_pix_out;

    typedef struct packed {
        t_conv_cfg cfg;
        t_pix_in   px;
        logic      by_hand;
        t_pix_out  want;
    } t_pixel_row;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PATTERN, RDY_TRICKLE} t_rdy_mode;

    // fields: direction, host_depth, has_alpha, host_prem, guest_prem
    localparam t_conv_cfg CF_RESET        = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam t_conv_cfg CF_UNPRE16      = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    localparam t_conv_cfg CF_RGB16        = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    localparam t_conv_cfg CF_UNPRE8       = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    localparam t_conv_cfg CF_HOST_UNPRE8  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam t_conv_cfg CF_HOST_PRE16   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    localparam t_conv_cfg CF_HOST_RGB16   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    localparam t_conv_cfg CF_HOST_PASS8   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    localparam t_pix_out  NO_HAND         = '0;

    // cfg, pixel {r, g, b, a, present}, hand checked, expected {r, g, b, a, cw, aw}
    localparam t_pixel_row DIRECTED_ROWS [21] = '{
        '{CF_RESET, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}, 1'b1,
          '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1, 1'b1}},
        '{CF_RESET, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1,
          '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1}},
        // upper byte must be dropped for an 8-bit host
        '{CF_RESET, '{16'hFF00, 16'hABCD, 16'h0080, 16'h0180, 1'b1}, 1'b0, NO_HAND},
        // missing host pixel reads as zeros
        '{CF_RESET, '{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0}, 1'b1,
          '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1}},
        '{CF_RESET, '{16'h0080, 16'h0040, 16'h00FF, 16'h0080, 1'b1}, 1'b0, NO_HAND},
        // zero alpha on unpremultiply, colour passes rescaled
        '{CF_UNPRE16, '{16'h8000, 16'hFFFF, 16'h0001, 16'h0000, 1'b1}, 1'b0, NO_HAND},
        '{CF_UNPRE16, '{16'hFFFF, 16'h1000, 16'h0FFF, 16'h1000, 1'b1}, 1'b0, NO_HAND},
        '{CF_UNPRE16, '{16'h0800, 16'h0001, 16'h0FFE, 16'h1000, 1'b1}, 1'b0, NO_HAND},
        // rgb host gets full scale alpha
        '{CF_RGB16, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1}, 1'b1,
          '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1, 1'b1}},
        '{CF_RGB16, '{16'h8000, 16'h7FFF, 16'h0000, 16'h1234, 1'b1}, 1'b0, NO_HAND},
        '{CF_HOST_UNPRE8, '{16'h00C8, 16'h0032, 16'h0064, 16'h0064, 1'b1}, 1'b0, NO_HAND},
        '{CF_HOST_UNPRE8, '{16'h004D, 16'h00FF, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_HAND},
        '{CF_HOST_UNPRE8, '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b0}, 1'b1,
          '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
        '{CF_HOST_PRE16, '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1}, 1'b1,
          '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1}},
        '{CF_HOST_PRE16, '{16'h0080, 16'h0001, 16'h00FE, 16'h0080, 1'b1}, 1'b0, NO_HAND},
        '{CF_HOST_PRE16, '{16'hAB12, 16'hFF00, 16'h7F80, 16'h0110, 1'b1}, 1'b0, NO_HAND},
        // rgb host on the way out: no alpha stored
        '{CF_HOST_RGB16, '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1}, 1'b1,
          '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0}},
        '{CF_HOST_RGB16, '{16'h0011, 16'h0022, 16'h0033, 16'h0044, 1'b0}, 1'b1,
          '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
        '{CF_UNPRE8, '{16'h000A, 16'h0014, 16'h00FF, 16'h0014, 1'b1}, 1'b0, NO_HAND},
        '{CF_UNPRE8, '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1}, 1'b1,
          '{16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF, 1'b1, 1'b1}},
        '{CF_HOST_PASS8, '{16'h0001, 16'h00FE, 16'h0080, 16'h007F, 1'b1}, 1'b0, NO_HAND}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    t_cfg_index                cfg_index = CFG_DIRECTION;
    logic                      cfg_data = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      o_s_axis_tready;
    logic [NUM_LANES*CH_W-1:0] s_data = '0;
    logic [0:0]                s_user = '0;
    logic                      o_m_axis_tvalid;
    logic                      m_ready = 1'b1;
    logic [NUM_LANES*CH_W-1:0] o_m_axis_tdata;
    logic [1:0]                o_m_axis_tuser;

    t_conv_cfg cfg_now = CF_RESET;
    t_pix_out  pending_pixels [$];
    int        mismatch_count = 0;
    int        results_seen = 0;
    int        pixels_sent = 0;
    int        missing_sent = 0;
    int        settings_loaded = 0;
    int        burst_left = 0;
    int        cycle_count = 0;
    t_rdy_mode ready_mode = RDY_ALWAYS;
    int        mode_left = 0;
    int        ready_tick = 0;
    t_pix_out  got_pixel;
    t_pix_out  want_pixel;

    rgba_depth_alpha_converter_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),    // in_red, in_green, in_blue, in_alpha
        .i_s_axis_tuser  (s_user),    // pixel_present
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // out_red, out_green, out_blue, out_alpha
        .o_m_axis_tuser  (o_m_axis_tuser)    // colour_write, alpha_write
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // floor(num / den + 1/2)
    function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic t_pix_out convert_pixel(t_conv_cfg c, t_pix_in p);
        longint unsigned hmax;
        longint unsigned a;
        longint unsigned ch;
        longint unsigned src [3];
        longint unsigned res [4];
        t_pix_out        o;
        int              i;
        hmax = c.host_depth ? 65535 : 255;
        src[0] = p.red;
        src[1] = p.green;
        src[2] = p.blue;
        for (i = 0; i < 4; i++) res[i] = 0;
        if (!c.direction) begin
            a = c.has_alpha ? (p.alpha & hmax) : hmax;
            o.colour_write = 1'b1;
            o.alpha_write = 1'b1;
            if (p.present) begin
                for (i = 0; i < 3; i++) begin
                    ch = src[i] & hmax;
                    if (c.guest_prem && !c.host_prem && c.has_alpha) begin
                        res[i] = round_div(ch * a * 255, hmax * hmax);
                    end else if (!c.guest_prem && c.host_prem && c.has_alpha && a > 0) begin
                        res[i] = (ch >= a) ? 255 : round_div(ch * 255, a);
                    end else begin
                        res[i] = round_div(ch * 255, hmax);
                    end
                end
                res[3] = round_div(a * 255, hmax);
            end
        end else begin
            a = p.alpha & 255;
            o.colour_write = p.present;
            o.alpha_write = p.present && c.has_alpha;
            if (p.present) begin
                for (i = 0; i < 3; i++) begin
                    ch = src[i] & 255;
                    if (c.guest_prem && !c.host_prem && c.has_alpha && a > 0) begin
                        res[i] = (ch >= a) ? hmax : round_div(ch * hmax, a);
                    end else if (!c.guest_prem && c.host_prem && c.has_alpha) begin
                        res[i] = round_div(ch * a * hmax, 255 * 255);
                    end else begin
                        res[i] = round_div(ch * hmax, 255);
                    end
                end
                res[3] = c.has_alpha ? round_div(a * hmax, 255) : 0;
            end
        end
        for (i = 0; i < 4; i++) begin
            if (res[i] > 65535) res[i] = 65535;
        end
        o.red   = res[0][CH_W-1:0];
        o.green = res[1][CH_W-1:0];
        o.blue  = res[2][CH_W-1:0];
        o.alpha = res[3][CH_W-1:0];
        return o;
    endfunction

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'h00FF;
            3: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // writes all five registers back to back, valid stays high across them
    task automatic load_settings(input t_conv_cfg s);
        t_cfg_index idx [5];
        logic       bits [5];
        int         k;
        idx = '{CFG_DIRECTION, CFG_HOST_DEPTH, CFG_HOST_ALPHA, CFG_HOST_PREM, CFG_GUEST_PREM};
        bits = '{s.direction, s.host_depth, s.has_alpha, s.host_prem, s.guest_prem};
        for (k = 0; k < 5; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= bits[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                CFG_DIRECTION:  cfg_now.direction  = bits[k];
                CFG_HOST_DEPTH: cfg_now.host_depth = bits[k];
                CFG_HOST_ALPHA: cfg_now.has_alpha  = bits[k];
                CFG_HOST_PREM:  cfg_now.host_prem  = bits[k];
                CFG_GUEST_PREM: cfg_now.guest_prem = bits[k];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // drop valid and wait for the pipeline to empty; waits on the clock before the first check
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_pixels.size() != 0);
    endtask

    task automatic send_pixel(input t_pix_in px, input logic by_hand, input t_pix_out hand_want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= {px.alpha, px.blue, px.green, px.red};
        s_user  <= px.present;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_pixels.insert(pending_pixels.size(),
                              by_hand ? hand_want : convert_pixel(cfg_now, px));
        pixels_sent++;
        if (!px.present) missing_sent++;
    endtask

    // receiver backpressure, switching between its own patterns
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= t_rdy_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        ready_tick <= ready_tick + 1;
        case (ready_mode)
            RDY_ALWAYS:  m_ready <= 1'b1;
            RDY_COIN:    m_ready <= 1'($urandom_range(0, 1));
            RDY_PATTERN: m_ready <= (ready_tick % 7) > 2;
            RDY_TRICKLE: m_ready <= (ready_tick % 16) == 0;
            default:     m_ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            got_pixel.red          = o_m_axis_tdata[0*CH_W +: CH_W];
            got_pixel.green        = o_m_axis_tdata[1*CH_W +: CH_W];
            got_pixel.blue         = o_m_axis_tdata[2*CH_W +: CH_W];
            got_pixel.alpha        = o_m_axis_tdata[3*CH_W +: CH_W];
            got_pixel.colour_write = o_m_axis_tuser[0];
            got_pixel.alpha_write  = o_m_axis_tuser[1];
            results_seen++;
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("beat %0d: unexpected output pixel %h", results_seen, got_pixel);
            end else begin
                want_pixel = pending_pixels.pop_front();
                if (got_pixel.red !== want_pixel.red || got_pixel.green !== want_pixel.green ||
                    got_pixel.blue !== want_pixel.blue || got_pixel.alpha !== want_pixel.alpha ||
                    got_pixel.colour_write !== want_pixel.colour_write ||
                    got_pixel.alpha_write !== want_pixel.alpha_write) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("beat %0d: expected r=%h g=%h b=%h a=%h cw=%b aw=%b",
                                 results_seen, want_pixel.red, want_pixel.green,
                                 want_pixel.blue, want_pixel.alpha, want_pixel.colour_write,
                                 want_pixel.alpha_write);
                        $display("    got r=%h g=%h b=%h a=%h cw=%b aw=%b",
                                 got_pixel.red, got_pixel.green,
                                 got_pixel.blue, got_pixel.alpha, got_pixel.colour_write,
                                 got_pixel.alpha_write);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, pending_pixels.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_pix_in   px;
        t_conv_cfg s;
        int        phase;
        int        n;
        int        k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, registers change only between drained groups
        for (k = 0; k < 21; k++) begin
            if (DIRECTED_ROWS[k].cfg != cfg_now) begin
                hold_until_drained();
                load_settings(DIRECTED_ROWS[k].cfg);
            end
            send_pixel(DIRECTED_ROWS[k].px, DIRECTED_ROWS[k].by_hand, DIRECTED_ROWS[k].want);
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            hold_until_drained();
            if (phase == 0) begin
                s = '0;
            end else if (phase == 1) begin
                s = '1;
            end else begin
                s.direction  = 1'($urandom_range(0, 1));
                s.host_depth = 1'($urandom_range(0, 1));
                s.has_alpha  = ($urandom_range(0, 3) != 0);
                s.host_prem  = 1'($urandom_range(0, 1));
                // lean toward mismatched conventions so the arithmetic paths get exercised
                s.guest_prem = ($urandom_range(0, 9) < 6) ? !s.host_prem
                                                          : 1'($urandom_range(0, 1));
            end
            load_settings(s);
            n = $urandom_range(40, 84);
            repeat (n) begin
                px.red   = rand_chan();
                px.green = rand_chan();
                px.blue  = rand_chan();
                px.alpha = rand_chan();
                // alpha right at a channel hits the saturation boundary
                if ($urandom_range(0, 3) == 0)
                    px.alpha = px.red + 16'($urandom_range(0, 2)) - 16'd1;
                px.present = ($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 199) == 0) hold_until_drained();
                send_pixel(px, 1'b0, NO_HAND);
            end
        end

        hold_until_drained();
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        $display("converted %0d pixels (%0d missing) across %0d register settings",
                 pixels_sent, missing_sent, settings_loaded);
        $display("%0d output beats checked, %0d left waiting", results_seen,
                 pending_pixels.size());
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
design/rdac_pkg.sv
design/rdac_lane.sv
design/rgba_depth_alpha_converter_unit.sv
bench/testbench.sv
